### rtl/json_key_value_extractor_defines.svh
// ----------------------------------------------------------------------------
// JSON key/value extractor assertion macros
// Shared property wrappers clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef JSON_KEY_VALUE_EXTRACTOR_DEFINES_SVH
`define JSON_KEY_VALUE_EXTRACTOR_DEFINES_SVH

// same-cycle implication
`define JKV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jkv assertion failed");

// next-cycle implication
`define JKV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jkv assertion failed");

`endif

### rtl/jkv_pkg.sv
// ----------------------------------------------------------------------------
// JSON key/value extractor package
// Shared types, codes and character constants.
// ----------------------------------------------------------------------------
package jkv_pkg;

	localparam int unsigned KEY_BYTES_DEF  = 8;
	localparam int unsigned DEPTH_BITS_DEF = 8;
	localparam int unsigned CFG_IDX_W      = 2;
	localparam int unsigned CFG_DATA_W     = 64;
	localparam int unsigned KEY_LEN_W      = 4;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_WORD   = 2'd0,
		REG_KEY_LENGTH = 2'd1,
		REG_ANY_DEPTH  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_SEARCH    = 2'd0,
		ST_FOUND     = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		VK_NONE      = 2'd0,
		VK_CONTAINER = 2'd1,
		VK_STRING    = 2'd2,
		VK_NUMBER    = 2'd3
	} value_kind_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic    in_value;
		logic    value_done;
		status_t status;
	} scan_result_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
	endfunction

	function automatic logic is_open(input logic [7:0] b);
		return (b == CH_LBRACE) || (b == CH_LBRACK);
	endfunction

	function automatic logic is_close(input logic [7:0] b);
		return (b == CH_RBRACE) || (b == CH_RBRACK);
	endfunction

endpackage

### rtl/jkv_in_stage.sv
// ----------------------------------------------------------------------------
// JSON key/value extractor input register
// Captures one byte item and hands it to the scanner.
// ----------------------------------------------------------------------------
module jkv_in_stage
	import jkv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] byte_value
	input  logic       s_tlast,
	input  logic       advance,
	output logic       valid_s1,
	output in_item_t   item_s1
);

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.byte_value <= s_tdata;
			item_s1.last       <= s_tlast;
		end
	end

endmodule

### rtl/jkv_scan.sv
// ----------------------------------------------------------------------------
// JSON key/value extractor scanner
// Document state and the per-byte key search and value extent logic.
// ----------------------------------------------------------------------------
module jkv_scan
	import jkv_pkg::*;
#(
	parameter int unsigned KEY_BYTES  = KEY_BYTES_DEF,
	parameter int unsigned DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  in_item_t                      item_s1,
	input  logic [KEY_BYTES-1:0][7:0]     key_bytes,
	input  logic [KEY_LEN_W-1:0]          key_length,
	input  logic                          any_depth,
	output scan_result_t                  result
);

	localparam int unsigned MPOS_W = $clog2(KEY_BYTES + 1);
	localparam int unsigned KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	typedef struct packed {
		logic                  started;
		logic [DEPTH_BITS-1:0] nest_depth;
		logic                  in_string;
		logic                  escape_pending;
		logic [MPOS_W-1:0]     match_position;
		logic                  match_alive;
		logic                  key_matched;
		logic                  awaiting_value;
		value_kind_t           value_kind;
		logic [DEPTH_BITS-1:0] value_depth;
		logic                  value_in_string;
		logic                  finished;
		logic                  found_any;
	} scan_state_t;

	scan_state_t st_q;
	scan_state_t st_nxt;

	always_comb begin
		logic [7:0]            b;
		logic [MPOS_W-1:0]     eff;
		logic [7:0]            kb;
		logic                  busy;
		logic                  str_open;
		logic                  str_close;
		logic                  next_in_str;
		logic                  done;
		logic                  iv;
		logic [DEPTH_BITS-1:0] dnew;
		status_t               stat;

		st_nxt = st_q;
		b      = item_s1.byte_value;
		iv     = 1'b0;
		done   = 1'b0;
		dnew   = '0;
		eff    = (key_length > KEY_LEN_W'(KEY_BYTES)) ? MPOS_W'(KEY_BYTES)
		                                              : MPOS_W'(key_length);
		kb     = (st_q.match_position < MPOS_W'(KEY_BYTES))
		         ? key_bytes[st_q.match_position[KIDX_W-1:0]] : 8'h00;
		busy        = (st_q.value_kind != VK_NONE) || st_q.awaiting_value;
		str_open    = !st_q.in_string && (b == CH_QUOTE);
		str_close   = st_q.in_string && !st_q.escape_pending && (b == CH_QUOTE);
		next_in_str = st_q.in_string ? !str_close : str_open;

		if (st_q.finished) begin
			st_nxt = st_q;
		end else if (!st_q.started) begin
			if (is_open(b)) begin
				st_nxt.started = 1'b1;
			end
		end else begin
			case (st_q.value_kind)
				VK_CONTAINER: begin
					iv = 1'b1;
					if (!st_q.value_in_string && is_open(b)) begin
						if (st_q.value_depth != '1) begin
							st_nxt.value_depth = st_q.value_depth + 1'b1;
						end
					end else if (!st_q.value_in_string && is_close(b)) begin
						dnew = (st_q.value_depth != '0) ? st_q.value_depth - 1'b1
						                                 : st_q.value_depth;
						st_nxt.value_depth = dnew;
						done = (dnew == '0);
					end
					st_nxt.value_in_string = next_in_str;
				end
				VK_STRING: begin
					iv   = 1'b1;
					done = str_close;
				end
				VK_NUMBER: begin
					if ((b == CH_COMMA) || is_space(b) || is_close(b)) begin
						done = 1'b1;
					end else begin
						iv = 1'b1;
					end
				end
				default: begin
					if (st_q.awaiting_value && !is_space(b)) begin
						st_nxt.awaiting_value = 1'b0;
						if (is_open(b)) begin
							st_nxt.value_kind      = VK_CONTAINER;
							st_nxt.value_depth     = DEPTH_BITS'(1);
							st_nxt.value_in_string = 1'b0;
							iv = 1'b1;
						end else if (b == CH_QUOTE) begin
							st_nxt.value_kind      = VK_STRING;
							st_nxt.value_in_string = 1'b1;
							iv = 1'b1;
						end else if ((b == CH_COMMA) || is_close(b)) begin
							done = 1'b1;
						end else begin
							st_nxt.value_kind = VK_NUMBER;
							iv = 1'b1;
						end
					end
				end
			endcase

			if (done) begin
				st_nxt.value_kind      = VK_NONE;
				st_nxt.value_depth     = '0;
				st_nxt.value_in_string = 1'b0;
				st_nxt.found_any       = 1'b1;
				if (!any_depth) begin
					st_nxt.finished = 1'b1;
				end
			end

			if (st_q.in_string) begin
				if (st_q.escape_pending) begin
					st_nxt.escape_pending = 1'b0;
					st_nxt.match_alive    = 1'b0;
				end else if (b == CH_BSLASH) begin
					st_nxt.escape_pending = 1'b1;
					st_nxt.match_alive    = 1'b0;
				end else if (b == CH_QUOTE) begin
					st_nxt.in_string = 1'b0;
					if (!busy) begin
						st_nxt.key_matched = st_q.match_alive && (st_q.match_position == eff);
					end
					st_nxt.match_alive = 1'b0;
				end else if (st_q.match_alive) begin
					if ((st_q.match_position < eff) && (b == kb)) begin
						st_nxt.match_position = st_q.match_position + 1'b1;
					end else begin
						st_nxt.match_alive = 1'b0;
					end
				end
			end else begin
				if (!busy && !is_space(b)) begin
					if ((b == CH_COLON) && st_q.key_matched) begin
						st_nxt.awaiting_value = 1'b1;
					end
					st_nxt.key_matched = 1'b0;
				end
				if (b == CH_QUOTE) begin
					st_nxt.in_string      = 1'b1;
					st_nxt.match_position = '0;
					st_nxt.match_alive    = !busy && (any_depth || (st_q.nest_depth == '0));
				end else if (is_open(b)) begin
					if (st_q.nest_depth != '1) begin
						st_nxt.nest_depth = st_q.nest_depth + 1'b1;
					end
				end else if (is_close(b)) begin
					if (st_q.nest_depth == '0) begin
						st_nxt.finished = 1'b1;
					end else begin
						st_nxt.nest_depth = st_q.nest_depth - 1'b1;
					end
				end
			end
		end

		stat = st_nxt.found_any ? ST_FOUND : (st_nxt.finished ? ST_NOT_FOUND : ST_SEARCH);
		if (item_s1.last) begin
			if (stat == ST_SEARCH) begin
				stat = ST_NOT_FOUND;
			end
			st_nxt = '0;
		end

		result.in_value   = iv;
		result.value_done = done;
		result.status     = stat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

endmodule

### rtl/jkv_out_stage.sv
// ----------------------------------------------------------------------------
// JSON key/value extractor result register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module jkv_out_stage
	import jkv_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  scan_result_t result,
	output logic         load_ok,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata   // [0] in_value, [1] value_done, [3:2] status, [7:4] zero
);

	scan_result_t res_q;

	assign load_ok = !m_tvalid || m_tready;
	assign m_tdata = {4'b0000, res_q.status, res_q.value_done, res_q.in_value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load_ok) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

endmodule

### rtl/json_key_value_extractor.sv
// ----------------------------------------------------------------------------
// JSON key/value extractor
// Marks the bytes of the value that follows a configured key in a JSON stream.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// s_*      in   s_tvalid/s_tready    byte_value in tdata, last as tlast
// m_*      out  m_tvalid/m_tready    in_value, value_done, status in tdata
// cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte per clock sustained unless m_tready stalls the result register. Each
// result is registered after input accept (input register, then the scan into the
// result register). The scan state update is one pass of combinational logic.
// Reset clears all scan state and loads key_word 0, key_length 1, any_depth 0.
// A stalled result register holds the input register, which then holds s_tready low.
// ----------------------------------------------------------------------------
`include "json_key_value_extractor_defines.svh"

module json_key_value_extractor
	import jkv_pkg::*;
#(
	parameter int unsigned KEY_BYTES  = KEY_BYTES_DEF,
	parameter int unsigned DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [7:0] byte_value
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,   // [0] in_value, [1] value_done, [3:2] status
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [KEY_BYTES-1:0][7:0] key_q;
	logic [KEY_LEN_W-1:0]      key_length_q;
	logic                      any_depth_q;
	logic                      valid_s1;
	in_item_t                  item_s1;
	scan_result_t              result;
	logic                      load_ok;
	logic                      advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q        <= '0;
			key_length_q <= KEY_LEN_W'(1);
			any_depth_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_KEY_WORD:   key_q        <= cfg_data[KEY_BYTES*8-1:0];
				REG_KEY_LENGTH: key_length_q <= cfg_data[KEY_LEN_W-1:0];
				REG_ANY_DEPTH:  any_depth_q  <= cfg_data[0];
				default:        key_q        <= key_q;
			endcase
		end
	end

	jkv_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	jkv_scan #(
		.KEY_BYTES  (KEY_BYTES),
		.DEPTH_BITS (DEPTH_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.item_s1    (item_s1),
		.key_bytes  (key_q),
		.key_length (key_length_q),
		.any_depth  (any_depth_q),
		.result     (result)
	);

	jkv_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.result   (result),
		.load_ok  (load_ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	`JKV_ASSERT_NOW(a_done_means_found, m_tvalid && m_tdata[1], m_tdata[3:2] == ST_FOUND)
	`JKV_ASSERT_NOW(a_ready_when_out_empty, !m_tvalid, s_tready)
	`JKV_ASSERT_NEXT(a_drain_when_no_item, m_tvalid && m_tready && !valid_s1, !m_tvalid)

endmodule
